### sv/gate_press_release_fsm_assert.svh
// assertion macros for the gate press/release block
`ifndef GATE_PRESS_RELEASE_FSM_ASSERT_SVH
`define GATE_PRESS_RELEASE_FSM_ASSERT_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define GPRF_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define GPRF_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`else

`define GPRF_ASSERT_SAME(label, clk, rst_n, cond, cons, msg)
`define GPRF_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg)

`endif

`endif

### sv/gprf_pkg.sv
// shared types and constants for the gate press/release block
`default_nettype none

package gprf_pkg;

    // event codes
    localparam logic [3:0] EV_SEC_OPEN_PRESS    = 4'd0;
    localparam logic [3:0] EV_DRV_OPEN_PRESS    = 4'd1;
    localparam logic [3:0] EV_SEC_OPEN_RELEASE  = 4'd2;
    localparam logic [3:0] EV_DRV_OPEN_RELEASE  = 4'd3;
    localparam logic [3:0] EV_SEC_CLOSE_PRESS   = 4'd4;
    localparam logic [3:0] EV_DRV_CLOSE_PRESS   = 4'd5;
    localparam logic [3:0] EV_SEC_CLOSE_RELEASE = 4'd6;
    localparam logic [3:0] EV_DRV_CLOSE_RELEASE = 4'd7;
    localparam logic [3:0] EV_OPEN_LIMIT        = 4'd8;
    localparam logic [3:0] EV_CLOSE_LIMIT       = 4'd9;
    localparam logic [3:0] EV_OBSTACLE          = 4'd10;

    // field widths
    localparam int TYPE_W  = 4;
    localparam int TIME_W  = 32;
    localparam int STATE_W = 3;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int THR_W      = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd500;
    localparam logic CFG_IDX_AUTO_THRESHOLD = 1'b0;

    // one input word
    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [TIME_W-1:0] time_ms;
        logic              drv_open_pin;
        logic              drv_close_pin;
        logic              sec_open_pin;
        logic              sec_close_pin;
    } req_t;

    // input register contents handed to the state logic
    typedef struct packed {
        logic valid;
        req_t req;
    } stage_t;

endpackage

`default_nettype wire

### sv/gprf_req_if.sv
// input channel carrying gate events
`default_nettype none

interface gprf_req_if
    import gprf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [TIME_W-1:0] time_ms;
    logic              drv_open_pin;
    logic              drv_close_pin;
    logic              sec_open_pin;
    logic              sec_close_pin;

    modport source (
        output valid, req_type, time_ms,
               drv_open_pin, drv_close_pin, sec_open_pin, sec_close_pin,
        input  ready
    );

    modport sink (
        input  valid, req_type, time_ms,
               drv_open_pin, drv_close_pin, sec_open_pin, sec_close_pin,
        output ready
    );
endinterface

`default_nettype wire

### sv/gprf_res_if.sv
// output channel carrying gate status
`default_nettype none

interface gprf_res_if
    import gprf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] gate_state;
    logic               auto_open;
    logic               auto_close;

    modport source (
        output valid, gate_state, auto_open, auto_close,
        input  ready
    );

    modport sink (
        input  valid, gate_state, auto_open, auto_close,
        output ready
    );
endinterface

`default_nettype wire

### sv/gate_press_release_fsm.sv
// Gate press/release controller top level.
// An accepted word is held in the input register; its status word is then written to the result register.
// Throughput: one event per cycle; the input register and the result register
// each move on whenever the next stage is empty or being drained.
// Reset: gate idle closed, all flags clear, auto threshold 500 ms.
`default_nettype none

`include "gate_press_release_fsm_assert.svh"

module gate_press_release_fsm
    import gprf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    gprf_req_if.sink                   req,
    gprf_res_if.source                 res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [THR_W-1:0] threshold;
    logic             advance;
    stage_t           stage;

    // configuration register
    gprf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    // input register
    gprf_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .stage   (stage)
    );

    // state machine and result register
    gprf_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .threshold (threshold),
        .advance   (advance),
        .res       (res)
    );

    // checks
    `GPRF_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, req.valid && req.ready, stage.valid, "accepted word did not reach the input register")
    `GPRF_ASSERT_SAME(a_stall_holds_input, clk, rst_n, stage.valid && res.valid && !res.ready, !req.ready, "input taken while both stages are full and stalled")
    `GPRF_ASSERT_SAME(a_auto_exclusive, clk, rst_n, res.valid, !(res.auto_open && res.auto_close), "auto open and auto close set together")
    `GPRF_ASSERT_NEXT(a_threshold_write, clk, rst_n, psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == CFG_IDX_AUTO_THRESHOLD), threshold == $past(pwdata[THR_W-1:0]), "threshold write lost")

endmodule

`default_nettype wire

### sv/gprf_cfg.sv
// apb register holding the auto-mode hold threshold
`default_nettype none

module gprf_cfg
    import gprf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [THR_W-1:0]      threshold
);

    logic             thr_sel;
    logic             thr_we;
    logic [THR_W-1:0] thr_reg;
    logic [THR_W-1:0] thr_next;

    // address decode on the word index
    assign thr_sel = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_AUTO_THRESHOLD);
    assign thr_we  = psel && penable && pwrite && thr_sel;
    assign thr_next = thr_we ? pwdata[THR_W-1:0] : thr_reg;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (thr_sel)
        begin
            prdata = {{(CFG_DATA_W-THR_W){1'b0}}, thr_reg};
        end
    end

    assign pready    = 1'b1;
    assign threshold = thr_reg;

endmodule

`default_nettype wire

### sv/gprf_in_stage.sv
// input register stage for gate events
`default_nettype none

module gprf_in_stage
    import gprf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gprf_req_if.sink    req,
    input  wire logic   advance,
    output stage_t      stage
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    logic load;

    // take a word whenever the register is empty or moves on this cycle
    assign req.ready = !valid_reg || advance;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg.req_type      <= req.req_type;
            req_reg.time_ms       <= req.time_ms;
            req_reg.drv_open_pin  <= req.drv_open_pin;
            req_reg.drv_close_pin <= req.drv_close_pin;
            req_reg.sec_open_pin  <= req.sec_open_pin;
            req_reg.sec_close_pin <= req.sec_close_pin;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.req   = req_reg;

endmodule

`default_nettype wire

### sv/gprf_fsm.sv
// gate state machine with registered status word
`default_nettype none

module gprf_fsm
    import gprf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stage_t           stage,
    input  wire logic [THR_W-1:0] threshold,
    output logic                  advance,
    gprf_res_if.source            res
);

    typedef enum logic [STATE_W-1:0] {
        GM_IDLE_CLOSED = 3'd0,
        GM_OPENING     = 3'd1,
        GM_IDLE_OPEN   = 3'd2,
        GM_CLOSING     = 3'd3,
        GM_STOPPED     = 3'd4,
        GM_REVERSING   = 3'd5
    } gate_mode_t;

    gate_mode_t         mode_reg, mode_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic               open_wait_reg, open_wait_next;
    logic               close_wait_reg, close_wait_next;
    logic               auto_open_reg, auto_open_next;
    logic               auto_close_reg, auto_close_next;
    logic               sec_open_held_reg, sec_open_held_next;
    logic               sec_close_held_reg, sec_close_held_next;
    logic               res_valid_reg, res_valid_next;
    logic [STATE_W-1:0] gate_state_reg;
    logic               auto_open_out_reg;
    logic               auto_close_out_reg;
    logic [TIME_W-1:0]  held;
    logic               short_hold;
    logic               conflict;
    logic               step;

    assign advance = !res_valid_reg || res.ready;
    assign step    = stage.valid && advance;

    // hold time, wrapping
    assign held       = stage.req.time_ms - start_reg;
    assign short_hold = held < {{(TIME_W-THR_W){1'b0}}, threshold};

    // both buttons of one panel pressed together
    assign conflict = (!stage.req.drv_open_pin && !stage.req.drv_close_pin) ||
                      (!stage.req.sec_open_pin && !stage.req.sec_close_pin);

    // next state for one event
    always_comb
    begin
        mode_next           = mode_reg;
        start_next          = start_reg;
        open_wait_next      = open_wait_reg;
        close_wait_next     = close_wait_reg;
        auto_open_next      = auto_open_reg;
        auto_close_next     = auto_close_reg;
        sec_open_held_next  = sec_open_held_reg;
        sec_close_held_next = sec_close_held_reg;

        unique case (stage.req.req_type)
            EV_SEC_OPEN_PRESS, EV_DRV_OPEN_PRESS:
            begin
                if (stage.req.req_type == EV_SEC_OPEN_PRESS)
                begin
                    sec_open_held_next = 1'b1;
                end
                if (stage.req.req_type == EV_SEC_OPEN_PRESS || !sec_close_held_reg)
                begin
                    mode_next       = GM_OPENING;
                    start_next      = stage.req.time_ms;
                    open_wait_next  = 1'b1;
                    close_wait_next = 1'b0;
                    auto_open_next  = 1'b0;
                    auto_close_next = 1'b0;
                end
            end
            EV_SEC_CLOSE_PRESS, EV_DRV_CLOSE_PRESS:
            begin
                if (stage.req.req_type == EV_SEC_CLOSE_PRESS)
                begin
                    sec_close_held_next = 1'b1;
                end
                if (stage.req.req_type == EV_SEC_CLOSE_PRESS || !sec_open_held_reg)
                begin
                    mode_next       = GM_CLOSING;
                    start_next      = stage.req.time_ms;
                    open_wait_next  = 1'b0;
                    close_wait_next = 1'b1;
                    auto_open_next  = 1'b0;
                    auto_close_next = 1'b0;
                end
            end
            EV_SEC_OPEN_RELEASE, EV_DRV_OPEN_RELEASE:
            begin
                if (stage.req.req_type == EV_SEC_OPEN_RELEASE)
                begin
                    sec_open_held_next = 1'b0;
                end
                if ((stage.req.req_type == EV_SEC_OPEN_RELEASE || !sec_close_held_reg) &&
                    open_wait_reg)
                begin
                    auto_open_next = short_hold;
                    if (!short_hold && mode_reg == GM_OPENING)
                    begin
                        mode_next = GM_STOPPED;
                    end
                    open_wait_next = 1'b0;
                end
            end
            EV_SEC_CLOSE_RELEASE, EV_DRV_CLOSE_RELEASE:
            begin
                if (stage.req.req_type == EV_SEC_CLOSE_RELEASE)
                begin
                    sec_close_held_next = 1'b0;
                end
                if ((stage.req.req_type == EV_SEC_CLOSE_RELEASE || !sec_open_held_reg) &&
                    close_wait_reg)
                begin
                    auto_close_next = short_hold;
                    if (!short_hold && mode_reg == GM_CLOSING)
                    begin
                        mode_next = GM_STOPPED;
                    end
                    close_wait_next = 1'b0;
                end
            end
            EV_OPEN_LIMIT:
            begin
                if (mode_reg == GM_OPENING || mode_reg == GM_REVERSING)
                begin
                    mode_next       = GM_IDLE_OPEN;
                    auto_open_next  = 1'b0;
                    auto_close_next = 1'b0;
                    open_wait_next  = 1'b0;
                end
            end
            EV_CLOSE_LIMIT:
            begin
                if (mode_reg == GM_CLOSING)
                begin
                    mode_next       = GM_IDLE_CLOSED;
                    auto_open_next  = 1'b0;
                    auto_close_next = 1'b0;
                    close_wait_next = 1'b0;
                end
            end
            EV_OBSTACLE:
            begin
                auto_close_next = 1'b0;
                close_wait_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        // panel conflict stops a running movement
        if (conflict && (mode_next == GM_OPENING || mode_next == GM_CLOSING))
        begin
            mode_next       = GM_STOPPED;
            auto_open_next  = 1'b0;
            auto_close_next = 1'b0;
            open_wait_next  = 1'b0;
            close_wait_next = 1'b0;
        end
    end

    // result valid flag
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (step)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= GM_IDLE_CLOSED;
            start_reg          <= '0;
            open_wait_reg      <= 1'b0;
            close_wait_reg     <= 1'b0;
            auto_open_reg      <= 1'b0;
            auto_close_reg     <= 1'b0;
            sec_open_held_reg  <= 1'b0;
            sec_close_held_reg <= 1'b0;
            res_valid_reg      <= 1'b0;
            gate_state_reg     <= '0;
            auto_open_out_reg  <= 1'b0;
            auto_close_out_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (step)
            begin
                mode_reg           <= mode_next;
                start_reg          <= start_next;
                open_wait_reg      <= open_wait_next;
                close_wait_reg     <= close_wait_next;
                auto_open_reg      <= auto_open_next;
                auto_close_reg     <= auto_close_next;
                sec_open_held_reg  <= sec_open_held_next;
                sec_close_held_reg <= sec_close_held_next;
                gate_state_reg     <= mode_next;
                auto_open_out_reg  <= auto_open_next;
                auto_close_out_reg <= auto_close_next;
            end
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.gate_state = gate_state_reg;
    assign res.auto_open  = auto_open_out_reg;
    assign res.auto_close = auto_close_out_reg;

endmodule

`default_nettype wire

### sim/tb_top.sv
// self-checking testbench for the gate press/release controller
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gprf_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_STALL  = 300;
    localparam int PHASE_WORDS = 215;
    localparam int NUM_PHASES  = 6;

    // unused event codes and pin patterns {drv_open, drv_close, sec_open, sec_close}
    localparam logic [3:0] EV_SPARE_LO = 4'd11;
    localparam logic [3:0] EV_SPARE_HI = 4'd15;
    localparam logic [3:0] PINS_IDLE   = 4'b1111;
    localparam logic [3:0] PINS_DRV_2  = 4'b0011;
    localparam logic [3:0] PINS_SEC_2  = 4'b1100;
    localparam logic [3:0] PINS_ALL    = 4'b0000;

    localparam logic [CFG_ADDR_W-1:0] THR_ADDR = {CFG_IDX_AUTO_THRESHOLD, 2'b00};

    typedef enum logic [2:0] {
        ST_IDLE_CLOSED = 3'd0,
        ST_OPENING     = 3'd1,
        ST_IDLE_OPEN   = 3'd2,
        ST_CLOSING     = 3'd3,
        ST_STOPPED     = 3'd4,
        ST_REVERSING   = 3'd5
    } gate_mode_e;

    typedef struct packed {
        logic [STATE_W-1:0] gate_state;
        logic               auto_open;
        logic               auto_close;
    } gate_status_t;

    typedef struct {
        req_t         w;
        bit           typed;
        gate_status_t want;
    } gate_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    gprf_req_if req_if ();
    gprf_res_if res_if ();

    gate_press_release_fsm i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF clk = ~clk;

    // predictor copy of the gate state
    gate_mode_e       pm_mode = ST_IDLE_CLOSED;
    logic [31:0]      pm_press_ms = '0;
    bit               pm_open_wait = 1'b0;
    bit               pm_close_wait = 1'b0;
    bit               pm_auto_open = 1'b0;
    bit               pm_auto_close = 1'b0;
    bit               pm_sec_open_held = 1'b0;
    bit               pm_sec_close_held = 1'b0;
    logic [THR_W-1:0] pm_threshold = THR_RESET;

    gate_status_t status_q[$];
    gate_row_t    gate_script[$];
    int           err_count = 0;
    int           cycle_count = 0;
    bit           idle_on = 1'b1;
    bit           long_stall_req = 1'b0;
    logic [31:0]  sim_ms = '0;

    // tag of the word currently on the request channel
    bit           cur_typed = 1'b0;
    gate_status_t cur_want = '0;

    function automatic void gate_begin(gate_mode_e m, logic [31:0] now, bit opening);
        pm_mode       = m;
        pm_press_ms   = now;
        pm_open_wait  = opening;
        pm_close_wait = !opening;
        pm_auto_open  = 1'b0;
        pm_auto_close = 1'b0;
    endfunction

    // release judged against the press time, modulo 2^32
    function automatic void gate_release(bit opening, logic [31:0] now);
        logic [31:0] held;
        bit          short_hold;
        held = now - pm_press_ms;
        short_hold = held < {16'd0, pm_threshold};
        if (opening && pm_open_wait) begin
            pm_auto_open = short_hold;
            if (!short_hold && pm_mode == ST_OPENING)
                pm_mode = ST_STOPPED;
            pm_open_wait = 1'b0;
        end else if (!opening && pm_close_wait) begin
            pm_auto_close = short_hold;
            if (!short_hold && pm_mode == ST_CLOSING)
                pm_mode = ST_STOPPED;
            pm_close_wait = 1'b0;
        end
    endfunction

    function automatic gate_status_t gate_predict(req_t w);
        gate_status_t s;
        bit           drv_both;
        bit           sec_both;
        case (w.req_type)
            EV_SEC_OPEN_PRESS: begin
                pm_sec_open_held = 1'b1;
                gate_begin(ST_OPENING, w.time_ms, 1'b1);
            end
            EV_DRV_OPEN_PRESS:
                if (!pm_sec_close_held)
                    gate_begin(ST_OPENING, w.time_ms, 1'b1);
            EV_SEC_OPEN_RELEASE: begin
                pm_sec_open_held = 1'b0;
                gate_release(1'b1, w.time_ms);
            end
            EV_DRV_OPEN_RELEASE:
                if (!pm_sec_close_held)
                    gate_release(1'b1, w.time_ms);
            EV_SEC_CLOSE_PRESS: begin
                pm_sec_close_held = 1'b1;
                gate_begin(ST_CLOSING, w.time_ms, 1'b0);
            end
            EV_DRV_CLOSE_PRESS:
                if (!pm_sec_open_held)
                    gate_begin(ST_CLOSING, w.time_ms, 1'b0);
            EV_SEC_CLOSE_RELEASE: begin
                pm_sec_close_held = 1'b0;
                gate_release(1'b0, w.time_ms);
            end
            EV_DRV_CLOSE_RELEASE:
                if (!pm_sec_open_held)
                    gate_release(1'b0, w.time_ms);
            EV_OPEN_LIMIT:
                if (pm_mode == ST_OPENING || pm_mode == ST_REVERSING) begin
                    pm_mode       = ST_IDLE_OPEN;
                    pm_auto_open  = 1'b0;
                    pm_auto_close = 1'b0;
                    pm_open_wait  = 1'b0;
                end
            EV_CLOSE_LIMIT:
                if (pm_mode == ST_CLOSING) begin
                    pm_mode       = ST_IDLE_CLOSED;
                    pm_auto_open  = 1'b0;
                    pm_auto_close = 1'b0;
                    pm_close_wait = 1'b0;
                end
            EV_OBSTACLE: begin
                pm_auto_close = 1'b0;
                pm_close_wait = 1'b0;
            end
            default: ;
        endcase

        // both buttons of one panel stop a running movement
        drv_both = !w.drv_open_pin && !w.drv_close_pin;
        sec_both = !w.sec_open_pin && !w.sec_close_pin;
        if ((drv_both || sec_both) && (pm_mode == ST_OPENING || pm_mode == ST_CLOSING)) begin
            pm_mode       = ST_STOPPED;
            pm_auto_open  = 1'b0;
            pm_auto_close = 1'b0;
            pm_open_wait  = 1'b0;
            pm_close_wait = 1'b0;
        end

        s.gate_state = pm_mode;
        s.auto_open  = pm_auto_open;
        s.auto_close = pm_auto_close;
        return s;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        err_count++;
    endtask

    function automatic void add_word(logic [3:0] ev, logic [31:0] t, logic [3:0] pins,
                                     bit typed = 1'b0, gate_mode_e m = ST_IDLE_CLOSED,
                                     bit ao = 1'b0, bit ac = 1'b0);
        gate_row_t r;
        r.w.req_type      = ev;
        r.w.time_ms       = t;
        r.w.drv_open_pin  = pins[3];
        r.w.drv_close_pin = pins[2];
        r.w.sec_open_pin  = pins[1];
        r.w.sec_close_pin = pins[0];
        r.typed           = typed;
        r.want.gate_state = m;
        r.want.auto_open  = ao;
        r.want.auto_close = ac;
        gate_script.push_back(r);
    endfunction

    // mostly no button held, now and then a random pin pattern
    function automatic logic [3:0] rand_pins();
        if ($urandom_range(0, 5) == 0)
            return 4'($urandom_range(0, 15));
        return PINS_IDLE;
    endfunction

    // hold time clustered around the threshold, sometimes anywhere
    function automatic logic [31:0] rand_hold();
        logic [31:0] thr;
        thr = {16'd0, pm_threshold};
        case ($urandom_range(0, 5))
            0: return (thr == 0) ? 32'd0 : thr - 1;
            1: return thr;
            2: return thr + 1;
            3: return $urandom_range(0, thr);
            4: return thr + $urandom_range(0, 2000);
            default: return $urandom();
        endcase
    endfunction

    function automatic void add_noise_word();
        sim_ms += $urandom_range(0, 300);
        add_word(4'($urandom_range(0, 15)), sim_ms, rand_pins());
    endfunction

    // press, optional noise, release, optional obstacle, then usually the matching limit
    function automatic void add_press_burst();
        bit         opening;
        bit         sec;
        logic [3:0] press_ev;
        opening = $urandom_range(0, 1);
        sec = $urandom_range(0, 1);
        if (opening)
            press_ev = sec ? EV_SEC_OPEN_PRESS : EV_DRV_OPEN_PRESS;
        else
            press_ev = sec ? EV_SEC_CLOSE_PRESS : EV_DRV_CLOSE_PRESS;
        add_word(press_ev, sim_ms, rand_pins());
        if ($urandom_range(0, 3) == 0)
            add_noise_word();
        sim_ms += rand_hold();
        add_word(press_ev + 4'd2, sim_ms, rand_pins());
        sim_ms += $urandom_range(1, 5000);
        if ($urandom_range(0, 9) == 0)
            add_word(EV_OBSTACLE, sim_ms, rand_pins());
        if ($urandom_range(0, 2) != 0)
            add_word(opening ? EV_OPEN_LIMIT : EV_CLOSE_LIMIT, sim_ms, rand_pins());
    endfunction

    task automatic send_gate_word(gate_row_t r);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= r.w.req_type;
        req_if.time_ms       <= r.w.time_ms;
        req_if.drv_open_pin  <= r.w.drv_open_pin;
        req_if.drv_close_pin <= r.w.drv_close_pin;
        req_if.sec_open_pin  <= r.w.sec_open_pin;
        req_if.sec_close_pin <= r.w.sec_close_pin;
        cur_typed            <= r.typed;
        cur_want             <= r.want;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // send the queued script, drop valid, wait for every status word
    task automatic run_gate_script();
        foreach (gate_script[i])
            send_gate_word(gate_script[i]);
        gate_script.delete();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THR_ADDR;
        pwdata  <= {{(CFG_DATA_W-THR_W){1'b0}}, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pm_threshold = v;
    endtask

    // accept monitor and status checker
    always @(posedge clk) begin : gate_monitor
        req_t         w;
        gate_status_t want;
        gate_status_t pred;
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch("status word with none expected");
                end else begin
                    want = status_q.pop_front();
                    if (res_if.gate_state !== want.gate_state)
                        report_mismatch($sformatf("gate_state got %0d want %0d",
                                                  res_if.gate_state, want.gate_state));
                    if (res_if.auto_open !== want.auto_open)
                        report_mismatch($sformatf("auto_open got %0b want %0b",
                                                  res_if.auto_open, want.auto_open));
                    if (res_if.auto_close !== want.auto_close)
                        report_mismatch($sformatf("auto_close got %0b want %0b",
                                                  res_if.auto_close, want.auto_close));
                end
            end
            if (req_if.valid && req_if.ready) begin
                w.req_type      = req_if.req_type;
                w.time_ms       = req_if.time_ms;
                w.drv_open_pin  = req_if.drv_open_pin;
                w.drv_close_pin = req_if.drv_close_pin;
                w.sec_open_pin  = req_if.sec_open_pin;
                w.sec_close_pin = req_if.sec_close_pin;
                pred = gate_predict(w);
                status_q.push_back(cur_typed ? cur_want : pred);
            end
        end
    end

    // status receiver: random bursts of back-pressure, one long hold-off on request
    initial begin : gate_receiver
        int n;
        int stall_count;
        res_if.ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (long_stall_req) begin
                res_if.ready <= 1'b0;
                stall_count = 0;
                while (stall_count < LONG_STALL) begin
                    @(negedge clk);
                    stall_count++;
                end
                long_stall_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n - 1) @(negedge clk);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // run watchdog
    initial begin : gate_watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : gate_main
        logic [THR_W-1:0] thr;
        req_if.valid         = 1'b0;
        req_if.req_type      = '0;
        req_if.time_ms       = '0;
        req_if.drv_open_pin  = 1'b1;
        req_if.drv_close_pin = 1'b1;
        req_if.sec_open_pin  = 1'b1;
        req_if.sec_close_pin = 1'b1;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset threshold
        add_word(EV_SPARE_LO, 32'd0, PINS_IDLE, 1'b1, ST_IDLE_CLOSED);
        add_word(EV_DRV_OPEN_PRESS, 32'd1000, PINS_IDLE, 1'b1, ST_OPENING);
        add_word(EV_DRV_OPEN_RELEASE, 32'd1100, PINS_IDLE);
        add_word(EV_OPEN_LIMIT, 32'd1200, PINS_IDLE, 1'b1, ST_IDLE_OPEN);
        // security close held blocks driver open
        add_word(EV_SEC_CLOSE_PRESS, 32'd2000, PINS_IDLE);
        add_word(EV_DRV_OPEN_PRESS, 32'd2010, PINS_IDLE);
        add_word(EV_DRV_OPEN_RELEASE, 32'd2020, PINS_IDLE);
        add_word(EV_SEC_CLOSE_RELEASE, 32'd2700, PINS_IDLE);
        add_word(EV_CLOSE_LIMIT, 32'd2800, PINS_IDLE);
        // hold time across the 32-bit wrap
        add_word(EV_DRV_CLOSE_PRESS, 32'hFFFF_FF00, PINS_IDLE);
        add_word(EV_DRV_CLOSE_RELEASE, 32'h0000_0010, PINS_IDLE);
        add_word(EV_OBSTACLE, 32'h0000_0020, PINS_IDLE);
        add_word(EV_CLOSE_LIMIT, 32'h0000_0030, PINS_IDLE, 1'b1, ST_IDLE_CLOSED);
        // security open held blocks driver close
        add_word(EV_SEC_OPEN_PRESS, 32'd5000, PINS_IDLE);
        add_word(EV_DRV_CLOSE_PRESS, 32'd5010, PINS_IDLE);
        add_word(EV_DRV_CLOSE_RELEASE, 32'd5020, PINS_IDLE);
        // panel conflicts on a spare code and right after a press
        add_word(EV_SPARE_HI, 32'd5030, PINS_DRV_2, 1'b1, ST_STOPPED);
        add_word(EV_SEC_OPEN_RELEASE, 32'd5040, PINS_IDLE);
        add_word(EV_DRV_CLOSE_PRESS, 32'd6000, PINS_SEC_2, 1'b1, ST_STOPPED);
        add_word(EV_DRV_CLOSE_RELEASE, 32'd6100, PINS_IDLE);
        // hold equal to the threshold stops, a second release is ignored
        add_word(EV_DRV_OPEN_PRESS, 32'd7000, PINS_IDLE);
        add_word(EV_DRV_OPEN_RELEASE, 32'd7500, PINS_IDLE);
        add_word(EV_DRV_OPEN_RELEASE, 32'd7600, PINS_IDLE);
        add_word(EV_OPEN_LIMIT, 32'hFFFF_FFFF, PINS_ALL);
        run_gate_script();

        // random phases over several thresholds, extremes first
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: thr = '0;
                1: thr = '1;
                2: thr = 16'd1;
                5: thr = THR_RESET;
                default: thr = 16'($urandom_range(0, 65535));
            endcase
            write_threshold(thr);
            idle_on = (p != NUM_PHASES - 1);
            if (p == 1)
                long_stall_req = 1'b1;
            while (gate_script.size() < PHASE_WORDS) begin
                if ($urandom_range(0, 4) == 0)
                    add_noise_word();
                else
                    add_press_burst();
            end
            run_gate_script();
        end

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
